// ===== design/ksmh_pkg.sv =====
// ----------------------------------------------------------------------------
// ksmh_pkg: shared types and constants for the k-th smallest min-heap block
// Holds the controller states, the datapath operations and the status codes.
// ----------------------------------------------------------------------------
package ksmh_pkg;

  localparam int VALUE_W  = 32;
  localparam int K_W      = 7;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_UP_ROOT,
    S_POP,
    S_POP_DATA,
    S_DN_CMP,
    S_FINISH
  } ksmh_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INSERT_ROOT,
    OP_INSERT,
    OP_DROP,
    OP_QUERY,
    OP_UP_SWAP,
    OP_UP_PLACE,
    OP_POP,
    OP_POP_DATA,
    OP_DN_SWAP,
    OP_DN_PLACE,
    OP_EMPTY,
    OP_LOAD_OUT
  } ksmh_op_t;

  typedef struct packed {
    logic is_insert;
    logic full;
    logic empty;
    logic up_swap;
    logic parent_root;
    logic dn_hold;
    logic kleft_zero;
  } ksmh_stat_t;

endpackage

// ===== design/ksmh_ram.sv =====
// ----------------------------------------------------------------------------
// ksmh_ram: generic memory with one write port and two read ports
// Both read ports are registered; each returns its word in the next cycle.
// ----------------------------------------------------------------------------
module ksmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== design/ksmh_dp.sv =====
// ----------------------------------------------------------------------------
// ksmh_dp: heap datapath
// Holds the heap memory, the entry count, the moving value and its position,
// the remaining rank and the result registers, and carries out one operation
// from the controller each cycle.
// ----------------------------------------------------------------------------
module ksmh_dp import ksmh_pkg::*; #(
  parameter int HEAP_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ksmh_op_t                  op,
  output ksmh_stat_t                stat,
  input  logic                      req_type,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [K_W-1:0]            k,
  output logic signed [VALUE_W-1:0] result_value,
  output logic [STATUS_W-1:0]       status
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = AW + 2;

  logic [CW-1:0]             count;
  logic [AW-1:0]             pos;
  logic signed [VALUE_W-1:0] v;
  logic signed [VALUE_W-1:0] res;
  logic [STATUS_W-1:0]       st;
  logic [K_W-1:0]            kleft;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [VALUE_W-1:0]        wdata;
  logic [AW-1:0]             raddr_a;
  logic [AW-1:0]             raddr_b;
  logic [VALUE_W-1:0]        rdata_a;
  logic [VALUE_W-1:0]        rdata_b;
  logic signed [VALUE_W-1:0] rda;
  logic signed [VALUE_W-1:0] rdb;

  logic [AW-1:0]             cnt_lo;
  logic [AW-1:0]             last_addr;
  logic [AW-1:0]             ins_parent;
  logic [AW-1:0]             pos_parent;
  logic [AW-1:0]             pos_gp;
  logic [IW-1:0]             cnt_x;
  logic [IW-1:0]             lc;
  logic [IW-1:0]             rc;
  logic                      sel_l;
  logic                      sel_r;
  logic signed [VALUE_W-1:0] bestv1;
  logic signed [VALUE_W-1:0] best_val;
  logic [AW-1:0]             best_pos;
  logic [IW-1:0]             blc;
  logic [IW-1:0]             brc;

  ksmh_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign rda = $signed(rdata_a);
  assign rdb = $signed(rdata_b);

  assign cnt_lo     = count[AW-1:0];
  assign last_addr  = cnt_lo - AW'(1);
  assign ins_parent = (cnt_lo - AW'(1)) >> 1;
  assign pos_parent = (pos - AW'(1)) >> 1;
  assign pos_gp     = (pos_parent - AW'(1)) >> 1;

  // Children of the hole during the sift-down; the left child wins a tie.
  assign cnt_x    = IW'(count);
  assign lc       = (IW'(pos) << 1) | IW'(1);
  assign rc       = lc + IW'(1);
  assign sel_l    = (lc < cnt_x) && (v > rda);
  assign bestv1   = sel_l ? rda : v;
  assign sel_r    = (rc < cnt_x) && (bestv1 > rdb);
  assign best_val = sel_r ? rdb : bestv1;
  assign best_pos = sel_r ? rc[AW-1:0] : lc[AW-1:0];
  assign blc      = (IW'(best_pos) << 1) | IW'(1);
  assign brc      = blc + IW'(1);

  always_comb begin
    stat.is_insert   = ~req_type;
    stat.full        = (count == CW'(HEAP_DEPTH));
    stat.empty       = (count == '0);
    stat.up_swap     = (rda > v);
    stat.parent_root = (pos_parent == '0);
    stat.dn_hold     = ~sel_l & ~sel_r;
    stat.kleft_zero  = (kleft == '0);
  end

  always_comb begin
    we      = 1'b0;
    waddr   = pos;
    wdata   = v;
    raddr_a = ins_parent;
    raddr_b = last_addr;
    case (op)
      OP_INSERT_ROOT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = value;
      end
      OP_INSERT: begin
        raddr_a = ins_parent;
      end
      OP_UP_SWAP: begin
        we      = 1'b1;
        wdata   = rda;
        raddr_a = pos_gp;
      end
      OP_UP_PLACE: begin
        we = 1'b1;
      end
      OP_POP: begin
        raddr_a = '0;
        raddr_b = last_addr;
      end
      OP_POP_DATA: begin
        raddr_a = AW'(1);
        raddr_b = AW'(2);
      end
      OP_DN_SWAP: begin
        we      = 1'b1;
        wdata   = best_val;
        raddr_a = blc[AW-1:0];
        raddr_b = brc[AW-1:0];
      end
      OP_DN_PLACE: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (op)
        OP_INSERT_ROOT, OP_INSERT: begin
          count <= count + CW'(1);
        end
        OP_POP: begin
          count <= count - CW'(1);
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_INSERT_ROOT: begin
        res <= '0;
        st  <= ST_OK;
      end
      OP_INSERT: begin
        v   <= value;
        pos <= cnt_lo;
        res <= '0;
        st  <= ST_OK;
      end
      OP_DROP: begin
        res <= '0;
        st  <= ST_FULL;
      end
      OP_QUERY: begin
        kleft <= (k == '0) ? K_W'(1) : k;
        res   <= '0;
        st    <= ST_OK;
      end
      OP_UP_SWAP: begin
        pos <= pos_parent;
      end
      OP_POP: begin
        kleft <= kleft - K_W'(1);
      end
      OP_POP_DATA: begin
        res <= rda;
        v   <= rdb;
        pos <= '0;
      end
      OP_DN_SWAP: begin
        pos <= best_pos;
      end
      OP_EMPTY: begin
        res <= '0;
        st  <= ST_EMPTY;
      end
      OP_LOAD_OUT: begin
        result_value <= res;
        status       <= st;
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HEAP_DEPTH))
    else $error("entry count above heap depth");

  a_drop_keeps: assert property (@(posedge clk) disable iff (rst)
    op == OP_DROP |=> count == $past(count))
    else $error("dropped insert changed the heap");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    op == OP_POP |=> count == $past(count) - CW'(1))
    else $error("removal did not shrink the heap by one");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (op == OP_LOAD_OUT && st != ST_OK) |-> res == '0)
    else $error("failed request carries a non-zero value");
`endif

endmodule

// ===== design/ksmh_ctrl.sv =====
// ----------------------------------------------------------------------------
// ksmh_ctrl: heap controller
// Sequences inserts, removals and sift steps, and owns the output valid flag.
// ----------------------------------------------------------------------------
module ksmh_ctrl import ksmh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  ksmh_stat_t stat,
  output ksmh_op_t   op
);

  ksmh_state_t state;
  ksmh_state_t state_next;
  logic        out_valid;
  logic        out_free;

  assign out_free = ~out_valid | m_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (!stat.is_insert) begin
            state_next = S_POP;
          end else if (stat.full || stat.empty) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_UP_CMP;
          end
        end
      end
      S_UP_CMP: begin
        if (!stat.up_swap) begin
          state_next = S_FINISH;
        end else if (stat.parent_root) begin
          state_next = S_UP_ROOT;
        end
      end
      S_UP_ROOT: begin
        state_next = S_FINISH;
      end
      S_POP: begin
        state_next = stat.empty ? S_FINISH : S_POP_DATA;
      end
      S_POP_DATA: begin
        if (!stat.empty) begin
          state_next = S_DN_CMP;
        end else begin
          state_next = stat.kleft_zero ? S_FINISH : S_POP;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_hold) begin
          state_next = stat.kleft_zero ? S_FINISH : S_POP;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (!stat.is_insert) begin
            op = OP_QUERY;
          end else if (stat.full) begin
            op = OP_DROP;
          end else if (stat.empty) begin
            op = OP_INSERT_ROOT;
          end else begin
            op = OP_INSERT;
          end
        end
      end
      S_UP_CMP: begin
        op = stat.up_swap ? OP_UP_SWAP : OP_UP_PLACE;
      end
      S_UP_ROOT: begin
        op = OP_UP_PLACE;
      end
      S_POP: begin
        op = stat.empty ? OP_EMPTY : OP_POP;
      end
      S_POP_DATA: begin
        op = OP_POP_DATA;
      end
      S_DN_CMP: begin
        op = stat.dn_hold ? OP_DN_PLACE : OP_DN_SWAP;
      end
      S_FINISH: begin
        if (out_free) begin
          op = OP_LOAD_OUT;
        end
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_LOAD_OUT) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/kth_smallest_min_heap.sv =====
// ----------------------------------------------------------------------------
// kth_smallest_min_heap: destructive k-th smallest selector on a min-heap
// Up to HEAP_DEPTH signed values are kept heap-ordered in a two-read-port
// memory. An insert sifts the new value up; a query removes the minimum k
// times (once if k is 0), sifting down after each, and returns the last one.
//
// The slave channel takes one request per item: tuser selects insert (0) or
// query (1), tdata carries the value and the rank. Every request yields one
// result item on the master channel with the value in tdata and the status
// in tuser (ok, heap ran empty, insert dropped because the heap is full).
// An insert into a non-empty heap climbs one level per compare step, at most
// log2(HEAP_DEPTH) levels; into an empty or full heap it goes straight to its
// result. A query takes, per removal, a pop step, a data step and a sift-down
// step per level visited (none if that empties the heap), and one more pop
// step if the heap runs empty. The sift loop walks one level per memory
// read. A new request is taken the cycle after the last result is loaded,
// while it may still wait in the output register. If the receiver stalls, a
// finished request holds in its last step until that register is free.
// Reset empties the heap and drops any pending result; no clearing pass is
// needed, as only entries below the count are ever used.
// ----------------------------------------------------------------------------
module kth_smallest_min_heap import ksmh_pkg::*; #(
  parameter int HEAP_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // value [31:0], k [38:32], zero [39]
  input  logic        s_tuser,  // req_type [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // result_value [31:0]
  output logic [1:0]  m_tuser   // status [1:0]
);

  ksmh_op_t                  op;
  ksmh_stat_t                stat;
  logic signed [VALUE_W-1:0] value;
  logic [K_W-1:0]            k;
  logic signed [VALUE_W-1:0] result_value;
  logic [STATUS_W-1:0]       status;

  assign value   = $signed(s_tdata[31:0]);
  assign k       = s_tdata[38:32];
  assign m_tdata = result_value;
  assign m_tuser = status;

  ksmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .op       (op)
  );

  ksmh_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .stat         (stat),
    .req_type     (s_tuser),
    .value        (value),
    .k            (k),
    .result_value (result_value),
    .status       (status)
  );

endmodule

// ===== tb/kth_smallest_min_heap_test.sv =====
// ----------------------------------------------------------------------------
// kth_smallest_min_heap_test: self-checking bench for the k-th smallest heap
// A scoreboard keeps its own min-heap and works out the result of every
// accepted request. Directed requests cover the extreme values, ties, rank
// zero, large ranks and queries on an empty heap. Random phases with varying
// insert and query mixes then fill, overflow and drain the heap, while both
// channels idle and stall at random. Each result item is checked in order.
// ----------------------------------------------------------------------------
localparam int  HEAP_SIZE  = 64;
localparam logic REQ_INSERT = 1'b0;
localparam logic REQ_QUERY  = 1'b1;

typedef struct packed {
  logic signed [31:0] value;
  logic [1:0]         status;
} heap_result_t;

class heap_scoreboard;
  logic signed [31:0] heap [HEAP_SIZE];
  int unsigned        count;
  heap_result_t       expected [$];
  int unsigned        errors;

  function new();
    count  = 0;
    errors = 0;
  endfunction

  function void sift_up(int unsigned pos);
    int unsigned        up;
    logic signed [31:0] t;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(heap[up] > heap[pos])) break;
      t        = heap[up];
      heap[up] = heap[pos];
      heap[pos] = t;
      pos      = up;
    end
  endfunction

  function void sift_down(int unsigned pos);
    int unsigned        lc;
    int unsigned        rc;
    int unsigned        best;
    logic signed [31:0] t;
    while (pos < count) begin
      lc   = 2 * pos + 1;
      rc   = 2 * pos + 2;
      best = pos;
      if (lc < count && heap[best] > heap[lc]) best = lc;
      if (rc < count && heap[best] > heap[rc]) best = rc;
      if (best == pos) break;
      t          = heap[best];
      heap[best] = heap[pos];
      heap[pos]  = t;
      pos        = best;
    end
  endfunction

  function logic signed [31:0] pop_min();
    logic signed [31:0] top;
    top     = heap[0];
    count   = count - 1;
    heap[0] = heap[count];
    sift_down(0);
    return top;
  endfunction

  function void note_request(logic req, logic signed [31:0] value, logic [6:0] rank);
    heap_result_t       r;
    int unsigned        n;
    int unsigned        i;
    logic signed [31:0] last;
    r.value  = '0;
    r.status = ksmh_pkg::ST_OK;
    last     = '0;
    if (req == REQ_INSERT) begin
      if (count >= HEAP_SIZE) begin
        r.status = ksmh_pkg::ST_FULL;
      end else begin
        heap[count] = value;
        count = count + 1;
        sift_up(count - 1);
      end
    end else begin
      n = (rank == 0) ? 1 : rank;
      for (i = 0; i < n; i++) begin
        if (count == 0) begin
          r.status = ksmh_pkg::ST_EMPTY;
          break;
        end
        last = pop_min();
      end
      if (r.status == ksmh_pkg::ST_OK) r.value = last;
    end
    expected.push_back(r);
  endfunction

  function void check_result(logic [31:0] value, logic [1:0] status);
    heap_result_t r;
    if (expected.size() == 0) begin
      $display("%0t: unexpected result item value %h status %0d", $time, value, status);
      errors++;
      return;
    end
    r = expected.pop_front();
    if (value !== r.value) begin
      $display("%0t: value expected %h actual %h", $time, r.value, value);
      errors++;
    end
    if (status !== r.status) begin
      $display("%0t: status expected %0d actual %0d", $time, r.status, status);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected.size();
  endfunction
endclass

module kth_smallest_min_heap_test;
  localparam int unsigned CYCLE_LIMIT  = 6000000;
  localparam int unsigned RANDOM_ITEMS = 1700;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;  // value [31:0], k [38:32], zero [39]
  logic        s_tuser  = 1'b0;  // req_type [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;  // result_value [31:0]
  logic [1:0]  m_tuser;  // status [1:0]

  heap_scoreboard score;
  bit             calm = 1'b0;
  int unsigned    cycle_count = 0;
  int unsigned    items_sent  = 0;

  kth_smallest_min_heap #(.HEAP_DEPTH(HEAP_SIZE)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    if (r < 8) return 32'($signed($urandom_range(0, 7)) - 4);
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [6:0] pick_rank();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 9);
    if (r < 5) return 7'($urandom_range(0, 3));
    if (r < 8) begin
      n = score.count + 1;
      return 7'($urandom_range(0, (n > 127) ? 127 : n));
    end
    if (r < 9) return 7'($urandom_range(0, 127));
    return 7'(score.count + $urandom_range(0, 1));
  endfunction

  task automatic send_request(input logic req, input logic [31:0] value,
                              input logic [6:0] rank);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, rank, value};
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    score.note_request(req, value, rank);
    items_sent++;
  endtask

  initial begin
    int unsigned stall;
    forever begin
      @(posedge clk);
      if (rst || calm) begin
        m_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) score.check_result(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("kth_smallest_min_heap: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned phase_len;
    int unsigned insert_pct;
    int unsigned i;
    score = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(REQ_QUERY,  32'h1234_5678, 7'd0);
    send_request(REQ_QUERY,  32'hFFFF_FFFF, 7'd127);
    send_request(REQ_INSERT, 32'h7FFF_FFFF, 7'd0);
    send_request(REQ_INSERT, 32'h8000_0000, 7'd127);
    send_request(REQ_INSERT, 32'h0000_0000, 7'd0);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 7'd127);
    send_request(REQ_INSERT, 32'h0000_0001, 7'd0);
    send_request(REQ_INSERT, 32'd5, 7'd0);
    send_request(REQ_INSERT, 32'd5, 7'd0);
    send_request(REQ_INSERT, 32'd5, 7'd0);
    send_request(REQ_QUERY,  32'h0000_0000, 7'd0);
    send_request(REQ_QUERY,  32'h0000_0000, 7'd1);
    send_request(REQ_QUERY,  32'h0000_0000, 7'd2);
    send_request(REQ_QUERY,  32'h0000_0000, 7'd3);
    send_request(REQ_QUERY,  32'h0000_0000, 7'd1);
    send_request(REQ_QUERY,  32'h0000_0000, 7'd1);
    send_request(REQ_INSERT, 32'd3, 7'h7F);
    send_request(REQ_INSERT, 32'd3, 7'h55);
    send_request(REQ_QUERY,  32'h7FFF_FFFF, 7'd64);

    while (items_sent < RANDOM_ITEMS) begin
      calm      = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0:       insert_pct = 20;
        1:       insert_pct = 50;
        2:       insert_pct = 80;
        default: insert_pct = 100;
      endcase
      for (i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 99) < insert_pct)
          send_request(REQ_INSERT, pick_value(), 7'($urandom_range(0, 127)));
        else
          send_request(REQ_QUERY, $urandom, pick_rank());
      end
    end
    s_tvalid <= 1'b0;

    while (score.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (score.errors == 0) begin
      $display("kth_smallest_min_heap: match");
    end else begin
      $display("kth_smallest_min_heap: mismatch");
    end
    $finish;
  end
endmodule

// ===== kth_smallest_min_heap.f =====
design/ksmh_pkg.sv
design/ksmh_ram.sv
design/ksmh_dp.sv
design/ksmh_ctrl.sv
design/kth_smallest_min_heap.sv
tb/kth_smallest_min_heap_test.sv
